// File: rtl/rrts_pkg.sv
`default_nettype none
package rrts_pkg;
    localparam int SLOTS_DEF = 16;

    localparam logic [2:0] MODE_CREATE_K = 3'd0;
    localparam logic [2:0] MODE_CREATE_U = 3'd1;
    localparam logic [2:0] MODE_START    = 3'd2;
    localparam logic [2:0] MODE_TICK     = 3'd3;
    localparam logic [2:0] MODE_EXIT     = 3'd4;

    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_NORUN   = 2'd2;
    localparam logic [1:0] STAT_NOUSER  = 2'd3;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]  mode;
        logic [47:0] frame;
        logic [51:0] root;
        logic [47:0] handle;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  slot;
        logic [1:0]  status;
        logic        switched;
        logic [63:0] resume_value;
        logic        load_root;
        logic [51:0] root_value;
        logic        free_space;
        logic [47:0] freed_handle;
    } t_res;
endpackage
`default_nettype wire

// File: rtl/rrts_front.sv
`default_nettype none
// Command queue: two-entry FIFO between the port and the slot engine.
module rrts_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire rrts_pkg::t_cmd i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output rrts_pkg::t_cmd    o_cmd,
    input  wire logic         i_pop
);
    import rrts_pkg::*;
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_q[r_wp] <= i_cmd;
                r_wp <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
endmodule
`default_nettype wire

// File: rtl/rrts_back.sv
`default_nettype none
// Slot engine: searches run one slot per cycle.
module rrts_back #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [51:0]    i_kroot,
    input  wire logic           i_valid,
    input  wire rrts_pkg::t_cmd i_cmd,
    output logic                o_pop,
    output logic                o_strobe,
    output rrts_pkg::t_res      o_res
);
    import rrts_pkg::*;
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_sst   [SLOTS];
    logic [47:0] r_frame [SLOTS];
    logic [51:0] r_root  [SLOTS];
    logic        r_user  [SLOTS];
    logic        r_start [SLOTS];
    logic [47:0] r_hdl   [SLOTS];
    logic [31:0] r_tick  [SLOTS];
    logic        r_has;
    logic [IW-1:0] r_cur, r_last;
    logic [CW-1:0] r_live;

    t_cmd          r_cmd;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_n;
    logic          r_found;
    t_res          r_res;
    logic          r_stb;

    logic [IW-1:0] w_next;
    logic          w_hit;

    always_comb begin
        w_hit = 1'b0;
        unique case (r_cmd.mode)
            MODE_CREATE_K, MODE_CREATE_U: w_hit = (r_sst[r_idx] == ST_UNUSED);
            MODE_START: w_hit = (r_sst[r_idx] == ST_READY);
            default: w_hit = (r_sst[r_idx] == ST_READY) || (r_sst[r_idx] == ST_RUNNING);
        endcase
        w_next = (r_idx == IW'(SLOTS - 1)) ? '0 : r_idx + 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: if (w_hit || r_n == CW'(SLOTS - 1)) n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_pop    = (r_state == S_IDLE) && i_valid;
    assign o_strobe = r_stb;
    assign o_res    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_has <= 1'b0;
            r_cur <= '0;
            r_last <= '0;
            r_live <= '0;
            r_stb <= 1'b0;
            r_found <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_sst[k] <= ST_UNUSED;
                r_frame[k] <= '0;
                r_root[k] <= '0;
                r_user[k] <= 1'b0;
                r_start[k] <= 1'b0;
                r_hdl[k] <= '0;
                r_tick[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_stb <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_cmd;
                    r_n <= '0;
                    r_found <= 1'b0;
                    r_res <= '0;
                    // linear searches start at 0, round robin after last pick
                    if (i_cmd.mode == MODE_TICK || i_cmd.mode == MODE_EXIT)
                        r_idx <= (r_last == IW'(SLOTS - 1)) ? '0 : r_last + 1'b1;
                    else
                        r_idx <= '0;
                    // exit frees the slot before searching
                    if (i_cmd.mode == MODE_EXIT && r_has && r_user[r_cur]) begin
                        r_sst[r_cur] <= ST_UNUSED;
                    end
                end
                S_SCAN: begin
                    if (w_hit) r_found <= 1'b1;
                    else begin
                        r_idx <= w_next;
                        r_n <= r_n + 1'b1;
                    end
                end
                S_FIN: begin
                    unique case (r_cmd.mode)
                        MODE_CREATE_K, MODE_CREATE_U: begin
                            if (r_found) begin
                                r_sst[r_idx] <= ST_READY;
                                r_frame[r_idx] <= r_cmd.frame;
                                r_tick[r_idx] <= '0;
                                r_root[r_idx] <= r_cmd.mode[0] ? r_cmd.root : i_kroot;
                                r_user[r_idx] <= r_cmd.mode[0];
                                r_start[r_idx] <= 1'b0;
                                r_hdl[r_idx] <= r_cmd.mode[0] ? r_cmd.handle : '0;
                                r_live <= r_live + 1'b1;
                                r_res.slot <= 4'(r_idx);
                            end else r_res.status <= STAT_FULL;
                        end
                        MODE_START: begin
                            if (r_found) begin
                                r_has <= 1'b1;
                                r_cur <= r_idx;
                                r_sst[r_idx] <= ST_RUNNING;
                                r_start[r_idx] <= 1'b1;
                                r_res.slot <= 4'(r_idx);
                                r_res.switched <= 1'b1;
                                r_res.resume_value <= {16'd0, r_frame[r_idx]};
                                r_res.load_root <= (r_root[r_idx] != '0);
                                r_res.root_value <= r_root[r_idx];
                            end else r_res.status <= STAT_NORUN;
                        end
                        MODE_TICK: if (r_has) begin
                            r_frame[r_cur] <= r_cmd.frame;
                            r_tick[r_cur] <= r_tick[r_cur] + 32'd1;
                            if (r_live > CW'(1) && r_found) r_last <= r_idx;
                            if (r_live > CW'(1) && r_found && r_idx != r_cur) begin
                                r_sst[r_cur] <= ST_READY;
                                r_cur <= r_idx;
                                r_sst[r_idx] <= ST_RUNNING;
                                r_start[r_idx] <= 1'b1;
                                r_res.slot <= 4'(r_idx);
                                r_res.switched <= 1'b1;
                                r_res.load_root <= (r_root[r_idx] != '0);
                                r_res.root_value <= r_root[r_idx];
                                r_res.resume_value <= {~r_start[r_idx] & ~r_user[r_idx],
                                    ~r_start[r_idx] & r_user[r_idx], 14'd0,
                                    r_frame[r_idx]};
                            end else r_res.slot <= 4'(r_cur);
                        end
                        MODE_EXIT: begin
                            if (!r_has || !r_user[r_cur]) r_res.status <= STAT_NOUSER;
                            else begin
                                r_res.free_space <= 1'b1;
                                r_res.freed_handle <= r_hdl[r_cur];
                                r_hdl[r_cur] <= '0;
                                r_live <= r_live - 1'b1;
                                if (!r_found) begin
                                    r_has <= 1'b0;
                                    r_res.status <= STAT_NORUN;
                                end else begin
                                    r_last <= r_idx;
                                    r_cur <= r_idx;
                                    r_sst[r_idx] <= ST_RUNNING;
                                    r_start[r_idx] <= 1'b1;
                                    r_res.slot <= 4'(r_idx);
                                    r_res.switched <= 1'b1;
                                    r_res.load_root <= 1'b1;
                                    r_res.root_value <= r_root[r_idx];
                                    r_res.resume_value <= {~r_start[r_idx] & ~r_user[r_idx],
                                        ~r_start[r_idx] & r_user[r_idx], 14'd0,
                                        r_frame[r_idx]};
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_OUT: r_stb <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/round_robin_task_scheduler.sv
// channel | direction | handshake         | payload
// cmd     | in        | i_start & !o_busy | i_mode, i_frame_addr, i_space_root_in,
//         |           |                   | i_space_handle_in
// result  | out       | o_done, one cycle | o_slot .. o_freed_handle
// config  | in        | i_cfg_we          | i_cfg_data (kernel_space_root)
// In the slot engine an item is taken from the queue in IDLE, the slot search
// in SCAN visits one slot per cycle, then FIN updates the table and result and
// OUT raises the strobe; o_done follows in the next cycle.
// Two items may wait in the command queue; o_busy rises when it is full.
// Reset is synchronous; the table is cleared at once, no clearing pass.
// The receiver cannot stall: o_done marks each result for one cycle.
`default_nettype none
module round_robin_task_scheduler #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [51:0] i_cfg_data,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [47:0] i_frame_addr,
    input  wire logic [51:0] i_space_root_in,
    input  wire logic [47:0] i_space_handle_in,
    output logic             o_done,
    output logic [3:0]       o_slot,
    output logic [1:0]       o_status,
    output logic             o_switched,
    output logic [63:0]      o_resume_value,
    output logic             o_load_root,
    output logic [51:0]      o_root_value,
    output logic             o_free_space,
    output logic [47:0]      o_freed_handle
);
    import rrts_pkg::*;
    logic [51:0] r_kroot;
    t_cmd w_in, w_q;
    t_res w_res;
    logic w_full, w_valid, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_kroot <= '0;
        else if (i_cfg_we) r_kroot <= i_cfg_data;
    end

    assign w_in = '{mode: i_mode, frame: i_frame_addr, root: i_space_root_in,
                    handle: i_space_handle_in};
    assign o_busy = w_full;

    rrts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_start && !w_full), .i_cmd(w_in),
        .o_full(w_full), .o_valid(w_valid), .o_cmd(w_q), .i_pop(w_pop)
    );

    rrts_back #(.SLOTS(SLOTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_kroot(r_kroot), .i_valid(w_valid),
        .i_cmd(w_q), .o_pop(w_pop), .o_strobe(o_done), .o_res(w_res)
    );

    assign o_slot = w_res.slot;
    assign o_status = w_res.status;
    assign o_switched = w_res.switched;
    assign o_resume_value = w_res.resume_value;
    assign o_load_root = w_res.load_root;
    assign o_root_value = w_res.root_value;
    assign o_free_space = w_res.free_space;
    assign o_freed_handle = w_res.freed_handle;
endmodule
`default_nettype wire

// File: rtl/rrts_checker.sv
`default_nettype none
module rrts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_busy,
    input wire logic        o_done,
    input wire logic [1:0]  o_status,
    input wire logic        o_switched,
    input wire logic        o_load_root,
    input wire logic        o_free_space
);
    import rrts_pkg::*;
    // o_done is never asserted back to back
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done twice");
    // a switch always reports ok
    a_sw_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_switched |-> o_status == STAT_OK) else $error("switch with error");
    // root load only with a switch
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_load_root |-> o_switched) else $error("root without switch");
    // a freed space comes only from a real exit
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_free_space |-> (o_status == STAT_OK || o_status == STAT_NORUN))
        else $error("free with bad status");
    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !o_busy) else $error("activity after reset");
endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_busy(o_busy),
    .o_done(o_done), .o_status(o_status), .o_switched(o_switched),
    .o_load_root(o_load_root), .o_free_space(o_free_space)
);
`default_nettype wire

// File: tb/sv/round_robin_task_scheduler_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module round_robin_task_scheduler_tb;
    import rrts_pkg::*;

    localparam int NSLOT     = 16;
    localparam int DRAIN_GAP = 25;
    localparam int WDOG_MAX  = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [51:0] i_cfg_data;
    logic        i_start;
    logic        o_busy;
    logic [2:0]  i_mode;
    logic [47:0] i_frame_addr;
    logic [51:0] i_space_root_in;
    logic [47:0] i_space_handle_in;
    logic        o_done;
    logic [3:0]  o_slot;
    logic [1:0]  o_status;
    logic        o_switched;
    logic [63:0] o_resume_value;
    logic        o_load_root;
    logic [51:0] o_root_value;
    logic        o_free_space;
    logic [47:0] o_freed_handle;

    round_robin_task_scheduler DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_mode           (i_mode),
        .i_frame_addr     (i_frame_addr),
        .i_space_root_in  (i_space_root_in),
        .i_space_handle_in(i_space_handle_in),
        .o_done           (o_done),
        .o_slot           (o_slot),
        .o_status         (o_status),
        .o_switched       (o_switched),
        .o_resume_value   (o_resume_value),
        .o_load_root      (o_load_root),
        .o_root_value     (o_root_value),
        .o_free_space     (o_free_space),
        .o_freed_handle   (o_freed_handle)
    );

    // scheduler shadow
    logic [1:0]  sh_state   [NSLOT];
    logic [47:0] sh_frame   [NSLOT];
    logic [51:0] sh_root    [NSLOT];
    bit          sh_user    [NSLOT];
    bit          sh_started [NSLOT];
    logic [47:0] sh_handle  [NSLOT];
    logic [31:0] sh_ticks   [NSLOT];
    bit          sh_has_cur;
    int          sh_cur;
    int          sh_live;
    int          sh_last_pick;
    logic [51:0] sh_kroot;

    t_res sched_q[$];
    t_res exp_r;
    int   mismatches;
    int   wdog;
    bit   allow_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int rr_search();
        int i;
        for (int n = 1; n <= NSLOT; n++) begin
            i = (sh_last_pick + n) % NSLOT;
            if (sh_state[i] == ST_READY || sh_state[i] == ST_RUNNING) begin
                sh_last_pick = i;
                return i;
            end
        end
        return NSLOT;
    endfunction

    function automatic logic [63:0] resume_frame(int i);
        logic [63:0] f;
        f = {16'd0, sh_frame[i]};
        if (!sh_started[i]) begin
            sh_started[i] = 1'b1;
            f[sh_user[i] ? 62 : 63] = 1'b1;
        end
        return f;
    endfunction

    function automatic int kernel_live();
        int k;
        k = 0;
        for (int i = 0; i < NSLOT; i++)
            if (sh_state[i] != ST_UNUSED && !sh_user[i]) k++;
        return k;
    endfunction

    function automatic void schedule(logic [2:0] m, logic [47:0] fr, logic [51:0] rt,
                                     logic [47:0] hd);
        t_res r;
        int   i;
        int   nx;
        r = '0;
        case (m)
            MODE_CREATE_K, MODE_CREATE_U: begin
                for (i = 0; i < NSLOT; i++)
                    if (sh_state[i] == ST_UNUSED) break;
                if (i == NSLOT) begin
                    r.status = STAT_FULL;
                end else begin
                    sh_state[i]   = ST_READY;
                    sh_frame[i]   = fr;
                    sh_ticks[i]   = '0;
                    sh_user[i]    = (m == MODE_CREATE_U);
                    sh_root[i]    = sh_user[i] ? rt : sh_kroot;
                    sh_started[i] = 1'b0;
                    sh_handle[i]  = sh_user[i] ? hd : '0;
                    sh_live++;
                    r.slot = i[3:0];
                end
            end
            MODE_START: begin
                for (i = 0; i < NSLOT; i++)
                    if (sh_state[i] == ST_READY) break;
                if (i == NSLOT) begin
                    r.status = STAT_NORUN;
                end else begin
                    sh_has_cur    = 1'b1;
                    sh_cur        = i;
                    sh_state[i]   = ST_RUNNING;
                    sh_started[i] = 1'b1;
                    r.slot         = i[3:0];
                    r.switched     = 1'b1;
                    r.resume_value = {16'd0, sh_frame[i]};
                    if (sh_root[i] != 0) begin
                        r.load_root  = 1'b1;
                        r.root_value = sh_root[i];
                    end
                end
            end
            MODE_TICK: begin
                if (sh_has_cur) begin
                    sh_frame[sh_cur] = fr;
                    sh_ticks[sh_cur] = sh_ticks[sh_cur] + 32'd1;
                    nx = sh_cur;
                    if (sh_live > 1) begin
                        i = rr_search();
                        if (i < NSLOT) nx = i;
                    end
                    r.slot = nx[3:0];
                    if (nx != sh_cur) begin
                        sh_state[sh_cur] = ST_READY;
                        sh_cur           = nx;
                        sh_state[nx]     = ST_RUNNING;
                        r.switched       = 1'b1;
                        if (sh_root[nx] != 0) begin
                            r.load_root  = 1'b1;
                            r.root_value = sh_root[nx];
                        end
                        r.resume_value = resume_frame(nx);
                    end
                end
            end
            MODE_EXIT: begin
                if (!sh_has_cur || !sh_user[sh_cur]) begin
                    r.status = STAT_NOUSER;
                end else begin
                    r.free_space      = 1'b1;
                    r.freed_handle    = sh_handle[sh_cur];
                    sh_handle[sh_cur] = '0;
                    sh_state[sh_cur]  = ST_UNUSED;
                    sh_live--;
                    nx = rr_search();
                    if (nx >= NSLOT) begin
                        sh_has_cur = 1'b0;
                        r.status   = STAT_NORUN;
                    end else begin
                        sh_cur         = nx;
                        sh_state[nx]   = ST_RUNNING;
                        r.slot         = nx[3:0];
                        r.switched     = 1'b1;
                        r.load_root    = 1'b1;
                        r.root_value   = sh_root[nx];
                        r.resume_value = resume_frame(nx);
                    end
                end
            end
            default: ;
        endcase
        sched_q.push_back(r);
    endfunction

    // caller sits on a rising edge; start stays high until someone idles the line
    task automatic send_item(logic [2:0] m, logic [47:0] fr, logic [51:0] rt,
                             logic [47:0] hd);
        i_start           <= 1'b1;
        i_mode            <= m;
        i_frame_addr      <= fr;
        i_space_root_in   <= rt;
        i_space_handle_in <= hd;
        do @(posedge i_clk); while (o_busy);
        schedule(m, fr, rt, hd);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        while (sched_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_kroot(logic [51:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sh_kroot = v;
    endtask

    function automatic logic [47:0] rnd48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [51:0] rnd_root();
        if ($urandom_range(0, 3) == 0) return '0;
        return 52'({$urandom, $urandom});
    endfunction

    task automatic send_rand(logic [2:0] m);
        send_item(m, rnd48(), rnd_root(), rnd48());
    endtask

    task automatic test_empty_table();
        send_rand(MODE_TICK);
        send_rand(MODE_EXIT);
        send_rand(MODE_START);
        send_rand(3'd5);
        send_rand(3'd6);
        send_rand(3'd7);
        wait_idle();
    endtask

    task automatic test_create_and_switch();
        write_kroot('0);
        send_item(MODE_CREATE_K, '0, '1, '1);
        // root register changes only with nothing in flight
        wait_idle();
        write_kroot('1);
        send_item(MODE_CREATE_K, '1, '0, '0);
        send_item(MODE_CREATE_U, '1, '1, '1);
        send_item(MODE_CREATE_U, 48'h1234_5678_9abc, '0, 48'h0f0f_0f0f_0f0f);
        send_rand(MODE_START);
        send_rand(MODE_START);
        repeat (4) send_rand(MODE_TICK);
        send_rand(MODE_EXIT);
        repeat (3) send_rand(MODE_TICK);
        send_rand(MODE_EXIT);
        wait_idle();
    endtask

    // fill to table full, then drain user tasks; the kernel tasks stay runnable
    task automatic test_fill_and_drain();
        repeat (NSLOT + 1) send_rand(MODE_CREATE_U);
        send_rand(MODE_START);
        repeat (NSLOT + 4) begin
            send_rand(MODE_TICK);
            send_rand(MODE_EXIT);
        end
        wait_idle();
    endtask

    task automatic test_random(int n, logic [51:0] kr, bit gaps);
        int r;
        write_kroot(kr);
        allow_gaps = gaps;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 12)      send_rand(kernel_live() < 5 ? MODE_CREATE_K : MODE_CREATE_U);
            else if (r < 32) send_rand(MODE_CREATE_U);
            else if (r < 42) send_rand(MODE_START);
            else if (r < 75) send_rand(MODE_TICK);
            else if (r < 95) send_rand(MODE_EXIT);
            else             send_rand(3'($urandom_range(5, 7)));
        end
        wait_idle();
    endtask

    task automatic cmp(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $display("%0t: %s expected %h actual %h", $time, name, e, a);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (sched_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual slot %h", $time, o_slot);
                mismatches++;
            end else begin
                exp_r = sched_q.pop_front();
                cmp("slot", 64'(exp_r.slot), 64'(o_slot));
                cmp("status", 64'(exp_r.status), 64'(o_status));
                cmp("switched", 64'(exp_r.switched), 64'(o_switched));
                cmp("resume_value", exp_r.resume_value, o_resume_value);
                cmp("load_root", 64'(exp_r.load_root), 64'(o_load_root));
                cmp("root_value", 64'(exp_r.root_value), 64'(o_root_value));
                cmp("free_space", 64'(exp_r.free_space), 64'(o_free_space));
                cmp("freed_handle", 64'(exp_r.freed_handle), 64'(o_freed_handle));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) begin
            wdog <= 0;
        end else if (wdog >= WDOG_MAX) begin
            $display("Mismatches found");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_start = 1'b0;
        i_mode = '0;
        i_frame_addr = '0;
        i_space_root_in = '0;
        i_space_handle_in = '0;
        mismatches = 0;
        wdog = 0;
        allow_gaps = 1'b1;
        sh_has_cur = 1'b0;
        sh_cur = 0;
        sh_live = 0;
        sh_last_pick = 0;
        sh_kroot = '0;
        for (int i = 0; i < NSLOT; i++) begin
            sh_state[i] = ST_UNUSED;
            sh_frame[i] = '0;
            sh_root[i] = '0;
            sh_user[i] = 1'b0;
            sh_started[i] = 1'b0;
            sh_handle[i] = '0;
            sh_ticks[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_create_and_switch();
        test_fill_and_drain();
        test_random(260, 52'({$urandom, $urandom}), 1'b1);
        test_random(260, '1, 1'b1);
        test_random(260, '0, 1'b0);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
